FILE: design/gspe_pkg.sv
// Shared types, constants and helpers for the grid shortest-path engine.
package gspe_pkg;

    localparam int MAX_ROWS  = 32;
    localparam int MAX_COLS  = 32;
    localparam int MAX_CELLS = 1024;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CELL_W = $clog2(MAX_CELLS);
    localparam int CNT_W  = CELL_W + 1;
    localparam int DIM_W  = 6;
    localparam int DIST_W = 11;
    localparam int OUT_DIST_W = 10;

    localparam logic [DIST_W-1:0] UNREACHED = '1;

    // APB byte addresses of the size registers
    localparam logic [2:0] ROWS_ADDR = 3'd0;
    localparam logic [2:0] COLS_ADDR = 3'd4;

    typedef enum logic [1:0] {
        CMD_WALL  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_READ  = 2'd2
    } command_t;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_S = 2'd1;
    localparam logic [1:0] DIR_W = 2'd2;
    localparam logic [1:0] DIR_E = 2'd3;

    // Neighbor visiting order (index order): north, west, east, south
    localparam logic [1:0] NB_N = 2'd0;
    localparam logic [1:0] NB_W = 2'd1;
    localparam logic [1:0] NB_E = 2'd2;
    localparam logic [1:0] NB_S = 2'd3;

    localparam logic [2:0] LAST_STEP = 3'd4;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_Q_SRC,
        ST_Q_TGT,
        ST_CLEAR,
        ST_SEED,
        ST_POP,
        ST_LOADU,
        ST_EXPAND,
        ST_TGT_CHK,
        ST_BACK,
        ST_MOVE_RD,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             wall;
        logic [ROW_W-1:0] target_row;
        logic [COL_W-1:0] target_col;
    } request_t;

    typedef struct packed {
        logic [OUT_DIST_W-1:0] distance;
        logic                  reachable;
        logic [1:0]            direction;
        logic                  move_valid;
        logic                  last;
    } result_t;

    // Clamp a size register to 1..max
    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] max);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) res = DIM_W'(1);
        else if (v > max) res = max;
        return res;
    endfunction

    // Linear wall-map index: row * cols + col
    function automatic logic [CELL_W-1:0] cell_index(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                                     logic [DIM_W-1:0] cols);
        logic [ROW_W+DIM_W:0] sum;
        sum = (ROW_W+DIM_W+1)'(r) * (ROW_W+DIM_W+1)'(cols) + (ROW_W+DIM_W+1)'(c);
        return sum[CELL_W-1:0];
    endfunction

endpackage

FILE: design/gspe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gspe_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: design/grid_shortest_path_engine.sv
// Grid shortest-path engine: wall map, breadth-first search and move readout.
//
// Usage: a request carries a command. A wall write stores one wall bit at
// row*grid_cols+col (ignored outside the grid). A query runs a breadth-first
// search from (row,col) to (target_row,target_col) and returns distance and
// reachable. A read returns the next stored move (N/S/W/E) with a last flag.
// Every request gives exactly one result on the result channel.
// A query clears the distance memory, then for each reached cell does one
// queue read, one distance read and four neighbor reads through the single
// read port of the distance memory, and then walks back along the path one
// move at a time.
// One request is in work at a time; request_ready is high only when idle.
// After reset the wall map is cleared to open, one cell a cycle, with
// request_ready low; register writes are taken meanwhile.
// When the receiver stalls, the finished result waits in the output register
// and the next result is held until that one has been taken.
// grid_rows and grid_cols lie at byte addresses 0 and 4 of the APB port.
module grid_shortest_path_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    output logic                request_ready,
    input  gspe_pkg::request_t  request,
    output logic                result_valid,
    input  logic                result_ready,
    output gspe_pkg::result_t   result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gspe_pkg::*;

    state_t state_reg, state_next;

    logic [DIM_W-1:0] rows_reg, cols_reg;
    logic [DIM_W-1:0] rows_eff, cols_eff;

    logic [ROW_W-1:0] src_row_reg, src_row_next, tgt_row_reg, tgt_row_next;
    logic [COL_W-1:0] src_col_reg, src_col_next, tgt_col_reg, tgt_col_next;
    logic             src_ok_reg, src_ok_next;
    logic [CELL_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next, nbr_row_reg, nbr_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next, nbr_col_reg, nbr_col_next;
    logic             nbr_in_reg, nbr_in_next;
    logic [1:0]       nbr_idx_reg, nbr_idx_next;
    logic [DIST_W-1:0] du_reg, du_next, dtot_reg, dtot_next;
    logic [2:0]       step_reg, step_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             found_reg, found_next;
    logic [ROW_W-1:0] sel_row_reg, sel_row_next;
    logic [COL_W-1:0] sel_col_reg, sel_col_next;
    logic [1:0]       sel_mv_reg, sel_mv_next;
    logic [CNT_W-1:0] mtot_reg, mtot_next, rptr_reg, rptr_next;
    result_t          res_reg, res_next, out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    // memory ports
    logic              wall_we, wall_wdata, wall_rdata;
    logic [CELL_W-1:0] wall_waddr, wall_raddr;
    logic              dist_we;
    logic [CELL_W-1:0] dist_waddr, dist_raddr;
    logic [DIST_W-1:0] dist_wdata, dist_rdata;
    logic              queue_we;
    logic [CELL_W-1:0] queue_waddr, queue_raddr, queue_wdata, queue_rdata;
    logic              move_we;
    logic [CELL_W-1:0] move_waddr, move_raddr;
    logic [1:0]        move_wdata, move_rdata;

    // neighbor of the current cell chosen by step
    logic [ROW_W-1:0] nb_row;
    logic [COL_W-1:0] nb_col;
    logic             nb_in;
    logic             accept, cfg_wr;
    logic             src_in, tgt_in, bfs_take, back_match;
    logic [DIST_W-1:0] want;
    logic [1:0]       cand_mv;

    gspe_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_wall_ram (
        .clk(clk), .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
        .raddr(wall_raddr), .rdata(wall_rdata)
    );
    gspe_ram #(.WIDTH(DIST_W), .DEPTH(MAX_CELLS)) u_dist_ram (
        .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
        .raddr(dist_raddr), .rdata(dist_rdata)
    );
    gspe_ram #(.WIDTH(CELL_W), .DEPTH(MAX_CELLS)) u_queue_ram (
        .clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
        .raddr(queue_raddr), .rdata(queue_rdata)
    );
    gspe_ram #(.WIDTH(2), .DEPTH(MAX_CELLS)) u_move_ram (
        .clk(clk), .we(move_we), .waddr(move_waddr), .wdata(move_wdata),
        .raddr(move_raddr), .rdata(move_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? 32'(cols_reg) : 32'(rows_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_W'(MAX_ROWS);
            cols_reg <= DIM_W'(MAX_COLS);
        end
        else if (cfg_wr)
        begin
            if (paddr[2]) cols_reg <= pwdata[DIM_W-1:0];
            else          rows_reg <= pwdata[DIM_W-1:0];
        end
    end

    assign rows_eff = clamp_dim(rows_reg, DIM_W'(MAX_ROWS));
    assign cols_eff = clamp_dim(cols_reg, DIM_W'(MAX_COLS));

    assign request_ready = (state_reg == ST_IDLE);
    assign accept        = request_valid && request_ready;
    assign result_valid  = out_valid_reg;
    assign result        = out_reg;

    assign src_in = (DIM_W'(request.row) < rows_eff) && (DIM_W'(request.col) < cols_eff);
    assign tgt_in = (DIM_W'(tgt_row_reg) < rows_eff) && (DIM_W'(tgt_col_reg) < cols_eff);

    // neighbor generator, order N, W, E, S
    always_comb
    begin
        nb_row = cur_row_reg;
        nb_col = cur_col_reg;
        nb_in  = 1'b0;
        unique case (step_reg[1:0])
            NB_N:
            begin
                nb_row = cur_row_reg - ROW_W'(1);
                nb_in  = (cur_row_reg != '0);
            end
            NB_W:
            begin
                nb_col = cur_col_reg - COL_W'(1);
                nb_in  = (cur_col_reg != '0);
            end
            NB_E:
            begin
                nb_col = cur_col_reg + COL_W'(1);
                nb_in  = (DIM_W'(cur_col_reg) + DIM_W'(1)) < cols_eff;
            end
            default:
            begin
                nb_row = cur_row_reg + ROW_W'(1);
                nb_in  = (DIM_W'(cur_row_reg) + DIM_W'(1)) < rows_eff;
            end
        endcase
    end

    // neighbor evaluation on the read data of the previous step
    assign bfs_take   = nbr_in_reg && !wall_rdata && (dist_rdata == UNREACHED);
    assign want       = DIST_W'(k_reg) - DIST_W'(1);
    assign back_match = nbr_in_reg && (dist_rdata == want);

    always_comb
    begin
        unique case (nbr_idx_reg)
            NB_N:    cand_mv = DIR_S;
            NB_W:    cand_mv = DIR_E;
            NB_E:    cand_mv = DIR_W;
            default: cand_mv = DIR_N;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:    if (cnt_reg == CELL_W'(MAX_CELLS - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == CMD_QUERY) state_next = ST_Q_SRC;
                    else if (request.command == CMD_READ && rptr_reg < mtot_reg)
                        state_next = ST_MOVE_RD;
                    else state_next = ST_RESP;
                end
            end
            ST_Q_SRC:   state_next = ST_Q_TGT;
            ST_Q_TGT:   state_next = (src_ok_reg && tgt_in && !wall_rdata) ? ST_CLEAR : ST_RESP;
            ST_CLEAR:   if (cnt_reg == CELL_W'(MAX_CELLS - 1)) state_next = ST_SEED;
            ST_SEED:    state_next = ST_POP;
            ST_POP:     state_next = (head_reg == tail_reg) ? ST_TGT_CHK : ST_LOADU;
            ST_LOADU:   state_next = ST_EXPAND;
            ST_EXPAND:  if (step_reg == LAST_STEP) state_next = ST_POP;
            ST_TGT_CHK:
            begin
                if (dist_rdata == UNREACHED || dist_rdata == '0) state_next = ST_RESP;
                else state_next = ST_BACK;
            end
            ST_BACK:
            begin
                if (step_reg == LAST_STEP && k_reg == CNT_W'(1)) state_next = ST_RESP;
            end
            ST_MOVE_RD: state_next = ST_RESP;
            ST_RESP:    if (!out_valid_reg || result_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        src_row_next = src_row_reg;
        src_col_next = src_col_reg;
        tgt_row_next = tgt_row_reg;
        tgt_col_next = tgt_col_reg;
        src_ok_next  = src_ok_reg;
        cnt_next     = cnt_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        nbr_row_next = nbr_row_reg;
        nbr_col_next = nbr_col_reg;
        nbr_in_next  = nbr_in_reg;
        nbr_idx_next = nbr_idx_reg;
        du_next      = du_reg;
        dtot_next    = dtot_reg;
        step_next    = step_reg;
        k_next       = k_reg;
        found_next   = found_reg;
        sel_row_next = sel_row_reg;
        sel_col_next = sel_col_reg;
        sel_mv_next  = sel_mv_reg;
        mtot_next    = mtot_reg;
        rptr_next    = rptr_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        out_valid_next = out_valid_reg && !result_ready;

        wall_we     = 1'b0;
        wall_waddr  = cnt_reg;
        wall_wdata  = 1'b0;
        wall_raddr  = cell_index(request.row, request.col, cols_eff);
        dist_we     = 1'b0;
        dist_waddr  = cnt_reg;
        dist_wdata  = UNREACHED;
        dist_raddr  = {nb_row, nb_col};
        queue_we    = 1'b0;
        queue_waddr = tail_reg[CELL_W-1:0];
        queue_wdata = {nbr_row_reg, nbr_col_reg};
        queue_raddr = head_reg[CELL_W-1:0];
        move_we     = 1'b0;
        move_waddr  = want[CELL_W-1:0];
        move_wdata  = cand_mv;
        move_raddr  = rptr_reg[CELL_W-1:0];

        unique case (state_reg)
            // wall map clear after reset
            ST_INIT:
            begin
                wall_we  = 1'b1;
                cnt_next = cnt_reg + CELL_W'(1);
            end
            ST_IDLE:
            begin
                res_next = '0;
                if (accept)
                begin
                    if (request.command == CMD_WALL && src_in)
                    begin
                        wall_we    = 1'b1;
                        wall_waddr = cell_index(request.row, request.col, cols_eff);
                        wall_wdata = request.wall;
                    end
                    if (request.command == CMD_QUERY)
                    begin
                        src_row_next = request.row;
                        src_col_next = request.col;
                        tgt_row_next = request.target_row;
                        tgt_col_next = request.target_col;
                        src_ok_next  = src_in;
                        mtot_next    = '0;
                        rptr_next    = '0;
                    end
                end
            end
            ST_Q_SRC:
            begin
                src_ok_next = src_ok_reg && !wall_rdata;
                wall_raddr  = cell_index(tgt_row_reg, tgt_col_reg, cols_eff);
                cnt_next    = '0;
            end
            ST_Q_TGT:   cnt_next = '0;
            // mark every cell unreached
            ST_CLEAR:
            begin
                dist_we  = 1'b1;
                cnt_next = cnt_reg + CELL_W'(1);
            end
            ST_SEED:
            begin
                dist_we     = 1'b1;
                dist_waddr  = {src_row_reg, src_col_reg};
                dist_wdata  = '0;
                queue_we    = 1'b1;
                queue_waddr = '0;
                queue_wdata = {src_row_reg, src_col_reg};
                head_next   = '0;
                tail_next   = CNT_W'(1);
            end
            ST_POP:
            begin
                dist_raddr = {tgt_row_reg, tgt_col_reg};
                if (head_reg != tail_reg) head_next = head_reg + CNT_W'(1);
            end
            ST_LOADU:
            begin
                cur_row_next = queue_rdata[CELL_W-1:COL_W];
                cur_col_next = queue_rdata[COL_W-1:0];
                dist_raddr   = queue_rdata;
                step_next    = '0;
            end
            // issue neighbor reads, settle the previous neighbor
            ST_EXPAND:
            begin
                wall_raddr   = cell_index(nb_row, nb_col, cols_eff);
                nbr_row_next = nb_row;
                nbr_col_next = nb_col;
                nbr_in_next  = nb_in;
                step_next    = step_reg + 3'd1;
                if (step_reg == '0) du_next = dist_rdata;
                else if (bfs_take)
                begin
                    dist_we    = 1'b1;
                    dist_waddr = {nbr_row_reg, nbr_col_reg};
                    dist_wdata = du_reg + DIST_W'(1);
                    queue_we   = 1'b1;
                    tail_next  = tail_reg + CNT_W'(1);
                end
            end
            ST_TGT_CHK:
            begin
                dtot_next    = dist_rdata;
                k_next       = CNT_W'(dist_rdata);
                cur_row_next = tgt_row_reg;
                cur_col_next = tgt_col_reg;
                step_next    = '0;
                found_next   = 1'b0;
                if (dist_rdata != UNREACHED)
                begin
                    res_next.reachable = 1'b1;
                end
            end
            // walk back one move
            ST_BACK:
            begin
                nbr_row_next = nb_row;
                nbr_col_next = nb_col;
                nbr_in_next  = nb_in;
                nbr_idx_next = step_reg[1:0];
                step_next    = step_reg + 3'd1;
                if (step_reg != '0 && !found_reg && back_match)
                begin
                    found_next   = 1'b1;
                    sel_row_next = nbr_row_reg;
                    sel_col_next = nbr_col_reg;
                    sel_mv_next  = cand_mv;
                end
                if (step_reg == LAST_STEP)
                begin
                    move_we    = 1'b1;
                    if (found_reg)
                    begin
                        move_wdata   = sel_mv_reg;
                        cur_row_next = sel_row_reg;
                        cur_col_next = sel_col_reg;
                    end
                    else if (back_match)
                    begin
                        move_wdata   = cand_mv;
                        cur_row_next = nbr_row_reg;
                        cur_col_next = nbr_col_reg;
                    end
                    else move_wdata = DIR_N;
                    found_next = 1'b0;
                    step_next  = '0;
                    k_next     = k_reg - CNT_W'(1);
                    if (k_reg == CNT_W'(1))
                    begin
                        mtot_next          = CNT_W'(dtot_reg);
                        res_next.reachable = 1'b1;
                        res_next.distance  = (dtot_reg > DIST_W'(1023)) ? '1 :
                                             dtot_reg[OUT_DIST_W-1:0];
                    end
                end
            end
            ST_MOVE_RD:
            begin
                res_next.direction  = move_rdata;
                res_next.move_valid = 1'b1;
                res_next.last       = (rptr_reg + CNT_W'(1) == mtot_reg);
                rptr_next           = rptr_reg + CNT_W'(1);
            end
            ST_RESP:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            step_reg      <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            mtot_reg      <= '0;
            rptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            found_reg     <= found_next;
            mtot_reg      <= mtot_next;
            rptr_reg      <= rptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        src_row_reg <= src_row_next;
        src_col_reg <= src_col_next;
        tgt_row_reg <= tgt_row_next;
        tgt_col_reg <= tgt_col_next;
        src_ok_reg  <= src_ok_next;
        cur_row_reg <= cur_row_next;
        cur_col_reg <= cur_col_next;
        nbr_row_reg <= nbr_row_next;
        nbr_col_reg <= nbr_col_next;
        nbr_in_reg  <= nbr_in_next;
        nbr_idx_reg <= nbr_idx_next;
        du_reg      <= du_next;
        dtot_reg    <= dtot_next;
        sel_row_reg <= sel_row_next;
        sel_col_reg <= sel_col_next;
        sel_mv_reg  <= sel_mv_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    // checks
    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= CNT_W'(MAX_CELLS))
        else $error("queue overflow");
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rptr_reg <= mtot_reg)
        else $error("read pointer beyond stored moves");
    a_back_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BACK |-> k_reg != '0)
        else $error("walk back with no move left");
endmodule
